// ===== rtl/dmchc_pkg.sv =====
package dmchc_pkg;

    localparam int unsigned MAX_LINES     = 16384;
    localparam int unsigned ADDRESS_WIDTH = 32;

    // legal ranges of the split widths
    localparam int unsigned OFF_MIN = 4;
    localparam int unsigned OFF_MAX = 8;
    localparam int unsigned IDX_MIN = 4;
    localparam int unsigned IDX_MAX = 14;

    localparam int unsigned OFF_RESET = 4;
    localparam int unsigned IDX_RESET = 8;

    localparam int unsigned CFG_W      = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/direct_mapped_cache_hit_counter.sv =====
// path: an accepted address passes the queue, the compare stage and the output register
// throughput: one address per cycle unless stalled, set by one tag ram read and one
//   tag ram write per cycle with same-line forwarding in the compare stage
// reset (synchronous, active low): counts and widths return to their reset values,
//   then the tag store is swept clear line by line with o_ready held low
module direct_mapped_cache_hit_counter #(
    parameter int unsigned MAX_LINES     = dmchc_pkg::MAX_LINES,
    parameter int unsigned ADDRESS_WIDTH = dmchc_pkg::ADDRESS_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dmchc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dmchc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ADDRESS_WIDTH-1:0]        i_address,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_hit,
    output logic [dmchc_pkg::COUNT_W-1:0]   o_hit_count,
    output logic [dmchc_pkg::COUNT_W-1:0]   o_miss_count
);

    localparam int unsigned SLOT_W = $clog2(MAX_LINES);
    localparam int unsigned TAG_W  =
        ADDRESS_WIDTH - dmchc_pkg::OFF_MIN - dmchc_pkg::IDX_MIN;

    logic                    push;
    logic                    pop;
    logic                    clr_busy;
    logic [SLOT_W-1:0]       f_slot;
    logic [TAG_W-1:0]        f_tag;
    logic [SLOT_W+TAG_W-1:0] q_data;
    dmchc_pkg::t_q_stat      q_stat;

    assign o_cfg_ready = 1'b1;

    dmchc_front #(
        .MAX_LINES    (MAX_LINES),
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_address  (i_address),
        .i_clr_busy (clr_busy),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_slot     (f_slot),
        .o_tag      (f_tag)
    );

    dmchc_queue #(
        .WIDTH(SLOT_W + TAG_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_slot, f_tag}),
        .i_pop  (pop),
        .o_data (q_data),
        .o_stat (q_stat)
    );

    dmchc_back #(
        .MAX_LINES    (MAX_LINES),
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_q_data    (q_data),
        .o_pop       (pop),
        .o_clr_busy  (clr_busy),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hit       (o_hit),
        .o_hit_count (o_hit_count),
        .o_miss_count(o_miss_count)
    );

endmodule

// ===== rtl/dmchc_ram.sv =====
module dmchc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dmchc_front.sv =====
module dmchc_front #(
    parameter int unsigned MAX_LINES     = dmchc_pkg::MAX_LINES,
    parameter int unsigned ADDRESS_WIDTH = dmchc_pkg::ADDRESS_WIDTH,
    localparam int unsigned SLOT_W = $clog2(MAX_LINES),
    localparam int unsigned TAG_W  = ADDRESS_WIDTH - dmchc_pkg::OFF_MIN - dmchc_pkg::IDX_MIN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [dmchc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dmchc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ADDRESS_WIDTH-1:0]        i_address,
    input  logic                            i_clr_busy,
    input  dmchc_pkg::t_q_stat              i_q_stat,
    output logic                            o_push,
    output logic [SLOT_W-1:0]               o_slot,
    output logic [TAG_W-1:0]                o_tag
);

    localparam int unsigned CW = dmchc_pkg::CFG_W;

    logic [CW-1:0]            r_off, n_off;
    logic [CW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            off_clamp;
    logic [CW-1:0]            idx_clamp;
    logic [ADDRESS_WIDTH-1:0] block;
    logic [ADDRESS_WIDTH-1:0] tag_full;
    logic [SLOT_W-1:0]        idx_mask;

    // widths are kept already clamped to their legal range
    always_comb begin
        if (i_cfg_data < CW'(dmchc_pkg::OFF_MIN)) begin
            off_clamp = CW'(dmchc_pkg::OFF_MIN);
        end else if (i_cfg_data > CW'(dmchc_pkg::OFF_MAX)) begin
            off_clamp = CW'(dmchc_pkg::OFF_MAX);
        end else begin
            off_clamp = i_cfg_data;
        end
        if (i_cfg_data < CW'(dmchc_pkg::IDX_MIN)) begin
            idx_clamp = CW'(dmchc_pkg::IDX_MIN);
        end else if (i_cfg_data > CW'(dmchc_pkg::IDX_MAX)) begin
            idx_clamp = CW'(dmchc_pkg::IDX_MAX);
        end else begin
            idx_clamp = i_cfg_data;
        end
        n_off = r_off;
        n_idx = r_idx;
        if (i_cfg_valid) begin
            if (i_cfg_index == dmchc_pkg::CFG_OFFSET_BITS) begin
                n_off = off_clamp;
            end
            if (i_cfg_index == dmchc_pkg::CFG_INDEX_BITS) begin
                n_idx = idx_clamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= CW'(dmchc_pkg::OFF_RESET);
            r_idx <= CW'(dmchc_pkg::IDX_RESET);
        end else begin
            r_off <= n_off;
            r_idx <= n_idx;
        end
    end

    // split the address into line index and tag
    always_comb begin
        for (int i = 0; i < SLOT_W; i++) begin
            idx_mask[i] = (i < int'(r_idx));
        end
    end

    assign block    = i_address >> r_off;
    assign tag_full = block >> r_idx;
    assign o_slot   = block[SLOT_W-1:0] & idx_mask;
    assign o_tag    = tag_full[TAG_W-1:0];

    assign o_ready = !i_clr_busy && !i_q_stat.full;
    assign o_push  = i_valid && o_ready;

endmodule

// ===== rtl/dmchc_queue.sv =====
module dmchc_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output dmchc_pkg::t_q_stat o_stat
);

    localparam int unsigned QD = dmchc_pkg::QUEUE_DEPTH;
    localparam int unsigned PW = $clog2(QD);
    localparam int unsigned CNTW = $clog2(QD + 1);

    logic [WIDTH-1:0] r_mem [QD];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CNTW-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(QD - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(QD - 1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CNTW'(QD));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== rtl/dmchc_back.sv =====
module dmchc_back #(
    parameter int unsigned MAX_LINES     = dmchc_pkg::MAX_LINES,
    parameter int unsigned ADDRESS_WIDTH = dmchc_pkg::ADDRESS_WIDTH,
    localparam int unsigned SLOT_W = $clog2(MAX_LINES),
    localparam int unsigned TAG_W  = ADDRESS_WIDTH - dmchc_pkg::OFF_MIN - dmchc_pkg::IDX_MIN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dmchc_pkg::t_q_stat            i_q_stat,
    input  logic [SLOT_W+TAG_W-1:0]       i_q_data,
    output logic                          o_pop,
    output logic                          o_clr_busy,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [dmchc_pkg::COUNT_W-1:0] o_hit_count,
    output logic [dmchc_pkg::COUNT_W-1:0] o_miss_count
);

    localparam int unsigned CNT_W = dmchc_pkg::COUNT_W;

    logic              r_clr_busy, n_clr_busy;
    logic [SLOT_W-1:0] r_clr_idx, n_clr_idx;

    logic              r_b_vld, n_b_vld;
    logic [SLOT_W-1:0] r_b_slot;
    logic [TAG_W-1:0]  r_b_tag;

    logic              r_fw_vld, n_fw_vld;
    logic [SLOT_W-1:0] r_fw_slot;
    logic [TAG_W-1:0]  r_fw_tag;

    logic              r_out_vld, n_out_vld;
    logic              r_out_hit;
    logic [CNT_W-1:0]  r_hits, n_hits;
    logic [CNT_W-1:0]  r_misses, n_misses;

    logic              b_fire;
    logic              hit;
    logic              line_vld;
    logic [TAG_W-1:0]  line_tag;
    logic [SLOT_W-1:0] q_slot;
    logic [TAG_W-1:0]  q_tag;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [TAG_W:0]    ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic [TAG_W:0]    ram_rdata;

    assign q_slot = i_q_data[SLOT_W+TAG_W-1:TAG_W];
    assign q_tag  = i_q_data[TAG_W-1:0];

    assign b_fire = r_b_vld && (!r_out_vld || i_ready);
    assign o_pop  = !i_q_stat.empty && (!r_b_vld || b_fire);

    // the read always targets the line of the item in the compare stage next cycle
    assign ram_raddr = o_pop ? q_slot : r_b_slot;

    // a write in the same cycle as the read is not seen by it, so take it from here
    always_comb begin
        if (r_fw_vld && (r_fw_slot == r_b_slot)) begin
            line_vld = 1'b1;
            line_tag = r_fw_tag;
        end else begin
            line_vld = ram_rdata[TAG_W];
            line_tag = ram_rdata[TAG_W-1:0];
        end
    end

    assign hit = line_vld && (line_tag == r_b_tag);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_b_slot;
        ram_wdata = {1'b1, r_b_tag};
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = '0;
        end else if (b_fire && !hit) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_idx  = r_clr_idx;
        if (r_clr_busy) begin
            n_clr_idx = r_clr_idx + SLOT_W'(1);
            if (r_clr_idx == SLOT_W'(MAX_LINES - 1)) begin
                n_clr_busy = 1'b0;
            end
        end

        n_b_vld = r_b_vld;
        if (o_pop) begin
            n_b_vld = 1'b1;
        end else if (b_fire) begin
            n_b_vld = 1'b0;
        end

        n_fw_vld = b_fire && !hit;

        n_out_vld = r_out_vld;
        n_hits    = r_hits;
        n_misses  = r_misses;
        if (b_fire) begin
            n_out_vld = 1'b1;
            if (hit) begin
                if (r_hits != '1) begin
                    n_hits = r_hits + CNT_W'(1);
                end
            end else begin
                if (r_misses != '1) begin
                    n_misses = r_misses + CNT_W'(1);
                end
            end
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_b_vld    <= 1'b0;
            r_fw_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_hits     <= '0;
            r_misses   <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_idx  <= n_clr_idx;
            r_b_vld    <= n_b_vld;
            r_fw_vld   <= n_fw_vld;
            r_out_vld  <= n_out_vld;
            r_hits     <= n_hits;
            r_misses   <= n_misses;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_slot <= q_slot;
            r_b_tag  <= q_tag;
        end
        if (b_fire) begin
            r_out_hit <= hit;
            r_fw_slot <= r_b_slot;
            r_fw_tag  <= r_b_tag;
        end
    end

    dmchc_ram #(
        .WIDTH(TAG_W + 1),
        .DEPTH(MAX_LINES)
    ) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_clr_busy   = r_clr_busy;
    assign o_valid      = r_out_vld;
    assign o_hit        = r_out_hit;
    assign o_hit_count  = r_hits;
    assign o_miss_count = r_misses;

endmodule

// ===== rtl/dmchc_checker.sv =====
module dmchc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_hit,
    input logic [dmchc_pkg::COUNT_W-1:0] o_hit_count,
    input logic [dmchc_pkg::COUNT_W-1:0] o_miss_count
);

    localparam int unsigned CNT_W = dmchc_pkg::COUNT_W;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit) && $stable(o_hit_count)
            && $stable(o_miss_count))
        else $error("result changed while stalled");

    // reset starts the clearing sweep with nothing shown
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("block not idle after reset");

    // hit count moves by one, and only with a new hit result
    a_hit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (o_hit_count != $past(o_hit_count)) |->
            o_valid && o_hit && (o_hit_count == CNT_W'($past(o_hit_count) + CNT_W'(1))))
        else $error("hit count stepped wrongly");

    // miss count moves by one, and only with a new miss result
    a_miss_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (o_miss_count != $past(o_miss_count)) |->
            o_valid && !o_hit && (o_miss_count == CNT_W'($past(o_miss_count) + CNT_W'(1))))
        else $error("miss count stepped wrongly");

endmodule

bind direct_mapped_cache_hit_counter dmchc_checker u_dmchc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_hit       (o_hit),
    .o_hit_count (o_hit_count),
    .o_miss_count(o_miss_count)
);

// ===== test/direct_mapped_cache_hit_counter_test.sv =====
`timescale 1ns / 100ps

module direct_mapped_cache_hit_counter_test;

    localparam int unsigned CW = dmchc_pkg::CFG_W;
    localparam int unsigned IW = dmchc_pkg::CFG_IDX_W;
    localparam int unsigned NW = dmchc_pkg::COUNT_W;

    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES     = 10;
    localparam int unsigned PHASES           = 8;
    localparam int unsigned PHASE_ITEMS      = 140;

    localparam logic [IW-1:0] REG_OFF = dmchc_pkg::CFG_OFFSET_BITS;
    localparam logic [IW-1:0] REG_IDX = dmchc_pkg::CFG_INDEX_BITS;
    // register slots with no register behind them
    localparam logic [IW-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [IW-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic {
        ROW_ADDR,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic          hit;
        logic [NW-1:0] hits;
        logic [NW-1:0] misses;
    } t_lookup_result;

    typedef struct packed {
        t_row_kind      kind;
        logic [IW-1:0]  reg_sel;
        logic [CW-1:0]  reg_data;
        logic [31:0]    addr;
        logic           typed;
        t_lookup_result want;
    } t_stim_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [IW-1:0] i_cfg_index;
    logic [CW-1:0] i_cfg_data;
    logic          i_valid;
    logic          o_ready;
    logic [31:0]   i_address;
    logic          o_valid;
    logic          i_ready;
    logic          o_hit;
    logic [NW-1:0] o_hit_count;
    logic [NW-1:0] o_miss_count;

    // predictor state
    bit            line_ok [dmchc_pkg::MAX_LINES];
    logic [31:0]   line_tag_copy [dmchc_pkg::MAX_LINES];
    logic [NW-1:0] hits_seen;
    logic [NW-1:0] misses_seen;
    logic [CW-1:0] offset_reg;
    logic [CW-1:0] index_reg;

    t_lookup_result pending_lookups [$];
    int unsigned    mismatch_count;
    int unsigned    result_number;
    bit             idle_enable;
    bit             long_hold_req;

    t_stim_row directed_rows [0:24];

    direct_mapped_cache_hit_counter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_address    (i_address),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hit        (o_hit),
        .o_hit_count  (o_hit_count),
        .o_miss_count (o_miss_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("direct_mapped_cache_hit_counter: mismatch");
        $finish;
    end

    task automatic predict_lookup(input logic [31:0] addr, output t_lookup_result res);
        logic [CW-1:0] off_w;
        logic [CW-1:0] idx_w;
        logic [31:0]   block;
        logic [31:0]   tag;
        logic [13:0]   slot;
        begin
            off_w = (offset_reg < dmchc_pkg::OFF_MIN) ? CW'(dmchc_pkg::OFF_MIN) :
                    (offset_reg > dmchc_pkg::OFF_MAX) ? CW'(dmchc_pkg::OFF_MAX) :
                    offset_reg;
            idx_w = (index_reg < dmchc_pkg::IDX_MIN) ? CW'(dmchc_pkg::IDX_MIN) :
                    (index_reg > dmchc_pkg::IDX_MAX) ? CW'(dmchc_pkg::IDX_MAX) :
                    index_reg;
            block = addr >> off_w;
            // a 14-bit index wraps the mask to all ones
            slot  = block[13:0] & ((14'd1 << idx_w) - 14'd1);
            tag   = block >> idx_w;
            res.hit = line_ok[slot] && (line_tag_copy[slot] == tag);
            if (res.hit) begin
                if (hits_seen != '1)
                    hits_seen = hits_seen + 1'b1;
            end else begin
                if (misses_seen != '1)
                    misses_seen = misses_seen + 1'b1;
                line_ok[slot]       = 1'b1;
                line_tag_copy[slot] = tag;
            end
            res.hits   = hits_seen;
            res.misses = misses_seen;
        end
    endtask

    task automatic wait_all_results();
        begin
            i_valid <= 1'b0;
            while (pending_lookups.size() != 0)
                @(posedge i_clk);
        end
    endtask

    task automatic send_lookup(input logic [31:0] addr, input logic typed,
                               input t_lookup_result want);
        t_lookup_result res;
        begin
            if (idle_enable && $urandom_range(0, 6) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            i_valid   <= 1'b1;
            i_address <= addr;
            do @(posedge i_clk); while (!o_ready);
            predict_lookup(addr, res);
            pending_lookups.push_back(typed ? want : res);
        end
    endtask

    task automatic write_reg(input logic [IW-1:0] sel, input logic [CW-1:0] data);
        begin
            wait_all_results();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= sel;
            i_cfg_data  <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
            if (sel == dmchc_pkg::CFG_OFFSET_BITS)
                offset_reg = data;
            else if (sel == dmchc_pkg::CFG_INDEX_BITS)
                index_reg = data;
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // result side: random stall bursts, one long hold on request
    initial begin
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
                i_ready <= 1'b1;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && o_valid && i_ready) begin
            result_number = result_number + 1;
            if (pending_lookups.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("result %0d with nothing pending: got %0b/%0d/%0d",
                             result_number, o_hit, o_hit_count, o_miss_count);
            end else begin
                want = pending_lookups.pop_front();
                if (o_hit !== want.hit || o_hit_count !== want.hits ||
                    o_miss_count !== want.misses) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("result %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                                 result_number, want.hit, want.hits, want.misses,
                                 o_hit, o_hit_count, o_miss_count);
                end
            end
        end
    end

    initial begin
        t_stim_row     row;
        logic [31:0]   addr_pool [16];
        logic [31:0]   addr;
        logic [CW-1:0] off_set;
        logic [CW-1:0] idx_set;
        int unsigned   pick;
        int unsigned   n;
        int unsigned   phase;

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= dmchc_pkg::CFG_OFFSET_BITS;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_address   <= '0;
        offset_reg     = CW'(dmchc_pkg::OFF_RESET);
        index_reg      = CW'(dmchc_pkg::IDX_RESET);
        hits_seen      = '0;
        misses_seen    = '0;
        mismatch_count = 0;
        result_number  = 0;
        idle_enable    = 1'b1;
        long_hold_req  = 1'b0;
        for (n = 0; n < 16; n++)
            addr_pool[n] = $urandom();

        directed_rows = '{
            // fresh after reset: offset 4, index 8
            '{ROW_ADDR, REG_OFF, 4'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'd0, 32'd1}},
            '{ROW_ADDR, REG_OFF, 4'd0, 32'h0000_0000, 1'b1, '{1'b1, 32'd1, 32'd1}},
            '{ROW_ADDR, REG_OFF, 4'd0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd1, 32'd2}},
            '{ROW_ADDR, REG_OFF, 4'd0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'd2, 32'd2}},
            // same block as address zero
            '{ROW_ADDR, REG_OFF, 4'd0, 32'h0000_000F, 1'b1, '{1'b1, 32'd3, 32'd2}},
            // same line, other tag: evicts, then evicted back
            '{ROW_ADDR, REG_OFF, 4'd0, 32'h0000_1000, 1'b1, '{1'b0, 32'd3, 32'd3}},
            '{ROW_ADDR, REG_OFF, 4'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'd3, 32'd4}},
            // offset below range acts as minimum
            '{ROW_CFG,  REG_OFF, 4'd0,  32'h0,         1'b0, '0},
            '{ROW_ADDR, REG_OFF, 4'd0,  32'h0000_0010, 1'b0, '0},
            // offset above range acts as maximum, stored lines survive
            '{ROW_CFG,  REG_OFF, 4'd15, 32'h0,         1'b0, '0},
            '{ROW_ADDR, REG_OFF, 4'd0,  32'h0000_00FF, 1'b0, '0},
            '{ROW_ADDR, REG_OFF, 4'd0,  32'h8000_0000, 1'b0, '0},
            // index below range
            '{ROW_CFG,  REG_IDX, 4'd0,  32'h0,         1'b0, '0},
            '{ROW_ADDR, REG_OFF, 4'd0,  32'h1234_5678, 1'b0, '0},
            '{ROW_ADDR, REG_OFF, 4'd0,  32'h1234_5678, 1'b0, '0},
            // index above range, top line of the store
            '{ROW_CFG,  REG_IDX, 4'd15, 32'h0,         1'b0, '0},
            '{ROW_ADDR, REG_OFF, 4'd0,  32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_ADDR, REG_OFF, 4'd0,  32'h003F_FF00, 1'b0, '0},
            // writes to unused slots change nothing
            '{ROW_CFG,  REG_SPARE_2, 4'd5,  32'h0,     1'b0, '0},
            '{ROW_CFG,  REG_SPARE_3, 4'd10, 32'h0,     1'b0, '0},
            '{ROW_ADDR, REG_OFF, 4'd0,  32'h003F_FF00, 1'b0, '0},
            '{ROW_CFG,  REG_OFF, 4'd8,  32'h0,         1'b0, '0},
            '{ROW_CFG,  REG_IDX, 4'd14, 32'h0,         1'b0, '0},
            '{ROW_ADDR, REG_OFF, 4'd0,  32'hAAAA_AAAA, 1'b0, '0},
            '{ROW_ADDR, REG_OFF, 4'd0,  32'h5555_5555, 1'b0, '0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < $size(directed_rows); n++) begin
            row = directed_rows[n];
            if (row.kind == ROW_CFG)
                write_reg(row.reg_sel, row.reg_data);
            else
                send_lookup(row.addr, row.typed, row.want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    off_set = 4'd4;
                    idx_set = 4'd4;
                end
                1: begin
                    off_set = 4'd8;
                    idx_set = 4'd14;
                end
                2: begin
                    off_set = 4'd4;
                    idx_set = 4'd14;
                end
                3: begin
                    off_set = 4'd8;
                    idx_set = 4'd4;
                end
                4: begin
                    off_set = 4'd0;
                    idx_set = 4'd15;
                end
                default: begin
                    off_set = CW'($urandom_range(0, 15));
                    idx_set = CW'($urandom_range(0, 15));
                end
            endcase
            write_reg(dmchc_pkg::CFG_OFFSET_BITS, off_set);
            write_reg(dmchc_pkg::CFG_INDEX_BITS, idx_set);
            if ($urandom_range(0, 2) == 0)
                write_reg(IW'($urandom_range(0, 3)), CW'($urandom_range(0, 15)));
            // the last phase runs at full rate on both sides
            idle_enable = (phase < PHASES - 1);
            if (phase == 2)
                long_hold_req = 1'b1;
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    // same block as a recent address
                    addr = addr_pool[$urandom_range(0, 15)] ^ 32'($urandom_range(0, 15));
                end else if (pick < 70) begin
                    // one bit flipped above the smallest block: neighbor line or tag
                    addr = addr_pool[$urandom_range(0, 15)] ^ (32'd1 << $urandom_range(4, 31));
                end else begin
                    addr = $urandom();
                    addr_pool[$urandom_range(0, 15)] = addr;
                end
                send_lookup(addr, 1'b0, '0);
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_lookups.size() == 0)
            $display("direct_mapped_cache_hit_counter: match");
        else
            $display("direct_mapped_cache_hit_counter: mismatch");
        $finish;
    end

endmodule
